[rtl/core/pdu_pkg.sv]
package pdu_pkg;

  localparam int MAX_BYTES = 6;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] PCT_BYTE = 8'h25;

  // One queued request: the bytes that one input character produces.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } rec_t;

endpackage

[rtl/core/pdu_front.sv]
module pdu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [20:0]   char_code,
  input  logic          last_char,
  input  logic          q_full,
  output logic          q_push,
  output pdu_pkg::rec_t q_wdata
);
  import pdu_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [20:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 21'h30 && c <= 21'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  logic [1:0]      phase;
  logic [1:0]      phase_next;
  logic [6:0]      held;
  logic [6:0]      held_next;
  logic            accept;
  logic [4:0]      hv_c;
  logic [4:0]      hv_h;
  logic [1:0][7:0] pre;
  logic [1:0]      npre;
  logic [3:0][7:0] body;
  logic [2:0]      nbody;
  logic [3:0][7:0] enc;
  logic [2:0]      enc_n;
  logic            do_idle;
  logic [2:0]      off;
  rec_t            rec;

  assign accept = push && !q_full;
  assign hv_c   = hex_value(char_code);
  assign hv_h   = hex_value({14'd0, held});

  // UTF-8 form of the current code point
  always_comb begin
    enc   = '0;
    enc_n = 3'd1;
    if (char_code < 21'h80) begin
      enc[0] = {1'b0, char_code[6:0]};
    end else if (char_code < 21'h800) begin
      enc[0] = {3'b110, char_code[10:6]};
      enc[1] = {2'b10, char_code[5:0]};
      enc_n  = 3'd2;
    end else if (char_code < 21'h10000) begin
      enc[0] = {4'b1110, char_code[15:12]};
      enc[1] = {2'b10, char_code[11:6]};
      enc[2] = {2'b10, char_code[5:0]};
      enc_n  = 3'd3;
    end else begin
      enc[0] = {5'b11110, char_code[20:18]};
      enc[1] = {2'b10, char_code[17:12]};
      enc[2] = {2'b10, char_code[11:6]};
      enc[3] = {2'b10, char_code[5:0]};
      enc_n  = 3'd4;
    end
  end

  always_comb begin
    phase_next = phase;
    held_next  = held;
    pre        = '0;
    npre       = 2'd0;
    body       = '0;
    nbody      = 3'd0;
    do_idle    = 1'b0;
    off        = '0;
    rec        = '0;
    unique case (phase)
      PH_PCT: begin
        if (hv_c[4] && !last_char) begin
          phase_next = PH_DIGIT;
          held_next  = char_code[6:0];
        end else begin
          pre[0]  = PCT_BYTE;
          npre    = 2'd1;
          do_idle = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hv_c[4] && hv_h[4]) begin
          body[0]    = {hv_h[3:0], hv_c[3:0]};
          nbody      = 3'd1;
          phase_next = PH_IDLE;
          held_next  = '0;
        end else begin
          // broken escape: flush '%' and the held digit literally
          pre[0]  = PCT_BYTE;
          pre[1]  = {1'b0, held};
          npre    = 2'd2;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase
    if (do_idle) begin
      phase_next = PH_IDLE;
      held_next  = '0;
      if (char_code == {13'd0, PCT_BYTE} && !last_char) begin
        phase_next = PH_PCT;
      end else begin
        body  = enc;
        nbody = enc_n;
      end
    end
    if (last_char) begin
      phase_next = PH_IDLE;
      held_next  = '0;
    end
    // pack literal prefix and body into one byte list
    for (int k = 0; k < MAX_BYTES; k++) begin
      off = 3'(k) - {1'b0, npre};
      if (3'(k) < {1'b0, npre}) begin
        rec.bytes[k] = pre[k % 2];
      end else begin
        rec.bytes[k] = body[off[1:0]];
      end
    end
    rec.cnt  = {1'b0, npre} + nbody;
    rec.last = last_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  assign q_push  = accept && (rec.cnt != 3'd0);
  assign q_wdata = rec;

endmodule

[rtl/core/pdu_queue.sv]
module pdu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  pdu_pkg::rec_t wdata,
  input  logic          rd,
  output pdu_pkg::rec_t rdata,
  output logic          full,
  output logic          empty
);
  import pdu_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[head];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= QPTR_W'(tail + 1'b1);
      end
      if (rd) begin
        head <= QPTR_W'(head + 1'b1);
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/pdu_back.sv]
module pdu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  pdu_pkg::rec_t q_rdata,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          end_of_output
);
  import pdu_pkg::*;

  rec_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       at_end;
  logic       take;

  assign at_end = (idx == cur.cnt - 3'd1);
  assign take   = cur_valid && pop;
  // load the next request when none is held or the current one is drained
  assign q_pop  = !q_empty && (!cur_valid || (take && at_end));

  assign empty         = !cur_valid;
  assign out_byte      = cur.bytes[idx];
  assign end_of_output = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

[rtl/core/percent_decoder_utf8_unit.sv]
// An item's first byte reaches the result ports via the queue and the request register.
// Throughput: one character accepted per cycle unless full; one result byte per cycle
// while pop is high. An n-byte item holds the result side until all n bytes are popped;
// a four-request queue between decode front and byte serialiser absorbs the difference.
// Reset (synchronous, active high) drops any pending escape, the queue and the output.
module percent_decoder_utf8_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [20:0] char_code,
  input  logic        last_char,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        end_of_output
);
  import pdu_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  rec_t q_wdata;
  rec_t q_rdata;

  assign full = q_full;

  pdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pdu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pdu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .end_of_output (end_of_output)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_last_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_char) |-> q_push)
    else $error("final character produced no request");

  a_mid_request: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !u_back.at_end) |=> !empty)
    else $error("request dropped before its bytes were delivered");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue written while full");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pdu_pkg::PCT_BYTE;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  localparam logic [20:0] CP_PCT = 21'h25;
  localparam int          N_REQS = 250;

  typedef struct {
    logic [20:0] cp;
    logic        fin;
    bit          hold;
    int          idle_pct;
    int          stall_pct;
  } char_req_t;

  typedef struct packed {
    logic [7:0] val;
    logic       eoo;
  } dec_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [20:0] char_code = '0;
  logic        last_char = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        end_of_output;

  char_req_t   char_reqs[$];
  dec_byte_t   exp_bytes[$];
  logic [7:0]  item_bytes[$];
  logic [1:0]  esc_phase = ESC_NONE;
  logic [6:0]  held_digit = '0;
  bit          req_taken = 1'b0;
  int          rx_stall_pct = 0;
  int          req_total = 0;
  int          err_cnt = 0;

  int          send_idle_tab[4] = '{0, 72, 0, 33};
  int          rx_stall_tab[4]  = '{0, 0, 72, 33};

  percent_decoder_utf8_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_code     (char_code),
    .last_char     (last_char),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_output (end_of_output)
  );

  always #10 clk = ~clk;

  // Byte predictor: percent escapes and UTF-8 encoding

  function automatic int hex_nibble(input logic [20:0] c);
    if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
    if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
    if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
    return -1;
  endfunction

  function automatic void utf8_encode(input logic [20:0] c);
    if (c < 21'h80) begin
      item_bytes.push_back(c[7:0]);
    end else if (c < 21'h800) begin
      item_bytes.push_back({3'b110, c[10:6]});
      item_bytes.push_back({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      item_bytes.push_back({4'b1110, c[15:12]});
      item_bytes.push_back({2'b10, c[11:6]});
      item_bytes.push_back({2'b10, c[5:0]});
    end else begin
      item_bytes.push_back({5'b11110, c[20:18]});
      item_bytes.push_back({2'b10, c[17:12]});
      item_bytes.push_back({2'b10, c[11:6]});
      item_bytes.push_back({2'b10, c[5:0]});
    end
  endfunction

  function automatic void plain_char(input logic [20:0] c, input logic fin);
    if (c == CP_PCT && !fin) begin
      esc_phase  = ESC_PCT;
      held_digit = '0;
    end else begin
      utf8_encode(c);
    end
  endfunction

  function automatic void decode_char(input logic [20:0] c, input logic fin);
    int hi;
    int lo;
    dec_byte_t b;
    item_bytes = {};
    case (esc_phase)
      ESC_PCT: begin
        if (hex_nibble(c) >= 0 && !fin) begin
          esc_phase  = ESC_DIGIT;
          held_digit = c[6:0];
        end else begin
          item_bytes.push_back(PCT_BYTE);
          esc_phase = ESC_NONE;
          plain_char(c, fin);
        end
      end
      ESC_DIGIT: begin
        hi = hex_nibble({14'd0, held_digit});
        lo = hex_nibble(c);
        if (hi >= 0 && lo >= 0) begin
          item_bytes.push_back({hi[3:0], lo[3:0]});
          esc_phase = ESC_NONE;
        end else begin
          item_bytes.push_back(PCT_BYTE);
          item_bytes.push_back({1'b0, held_digit});
          esc_phase = ESC_NONE;
          plain_char(c, fin);
        end
      end
      default: begin
        esc_phase = ESC_NONE;
        plain_char(c, fin);
      end
    endcase
    if (fin) esc_phase = ESC_NONE;
    if (esc_phase != ESC_DIGIT) held_digit = '0;
    foreach (item_bytes[k]) begin
      b.val = item_bytes[k];
      b.eoo = fin && (k == item_bytes.size() - 1);
      exp_bytes.push_back(b);
    end
  endfunction

  // Request driver

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (char_reqs.size() == 0) begin
        push <= 1'b0;
      end else if (char_reqs[0].hold && exp_bytes.size() != 0) begin
        push <= 1'b0;
      end else if ($urandom_range(99) < char_reqs[0].idle_pct) begin
        push <= 1'b0;
      end else begin
        push         <= 1'b1;
        char_code    <= char_reqs[0].cp;
        last_char    <= char_reqs[0].fin;
        rx_stall_pct = char_reqs[0].stall_pct;
        void'(char_reqs.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= rx_stall_pct);
  end

  // Monitor: check popped bytes, then predict from the accepted request

  always @(posedge clk) begin
    dec_byte_t e;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected byte: out_byte %h end_of_output %b", out_byte, end_of_output);
          err_cnt++;
        end else begin
          e = exp_bytes.pop_front();
          if (out_byte !== e.val) begin
            $error("out_byte: expected %h, actual %h", e.val, out_byte);
            err_cnt++;
          end
          if (end_of_output !== e.eoo) begin
            $error("end_of_output: expected %b, actual %b", e.eoo, end_of_output);
            err_cnt++;
          end
        end
      end
      req_taken = push && !full;
      if (req_taken) decode_char(char_code, last_char);
    end
  end

  // Stimulus

  function automatic void add_req(input logic [20:0] cp, input logic fin);
    char_req_t r;
    int ph;
    ph          = (req_total / 40) % 4;
    r.cp        = cp;
    r.fin       = fin;
    r.hold      = (req_total % 100 == 50);
    r.idle_pct  = send_idle_tab[ph];
    r.stall_pct = rx_stall_tab[ph];
    char_reqs.push_back(r);
    req_total++;
  endfunction

  function automatic logic [20:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(21);
    if (v < 10) return 21'(21'h30 + v);
    if (v < 16) return 21'(21'h61 + v - 10);
    return 21'(21'h41 + v - 16);
  endfunction

  function automatic logic [20:0] rand_code_point();
    case ($urandom_range(9))
      0, 1, 2: return 21'($urandom_range(21'h7F));
      3:       return rand_hex_char();
      4:       return CP_PCT;
      5:       return 21'($urandom_range(21'h7FF, 21'h80));
      6:       return 21'($urandom_range(21'hFFFF, 21'h800));
      7:       return 21'($urandom_range(21'hDFFF, 21'hD800));
      8:       return 21'($urandom_range(21'h10FFFF, 21'h10000));
      default: return 21'($urandom_range(21'h1FFFFF, 21'h110000));
    endcase
  endfunction

  initial begin
    logic fin;
    logic [20:0] c;

    // boundaries of each UTF-8 length, surrogates and beyond-Unicode values
    add_req(21'h0, 1'b0);
    add_req(21'h7F, 1'b0);
    add_req(21'h80, 1'b0);
    add_req(21'h7FF, 1'b0);
    add_req(21'h800, 1'b0);
    add_req(21'hD800, 1'b0);
    add_req(21'hDFFF, 1'b0);
    add_req(21'hFFFF, 1'b0);
    add_req(21'h10000, 1'b0);
    add_req(21'h10FFFF, 1'b0);
    add_req(21'h1FFFFF, 1'b1);
    // well-formed escapes, mixed case
    add_req(CP_PCT, 1'b0); add_req(21'h66, 1'b0); add_req(21'h46, 1'b0);
    add_req(CP_PCT, 1'b0); add_req(21'h30, 1'b0); add_req(21'h39, 1'b0);
    // broken escapes, a new escape straight after a broken one
    add_req(CP_PCT, 1'b0); add_req(21'h67, 1'b0);
    add_req(CP_PCT, 1'b0); add_req(21'h41, 1'b0); add_req(CP_PCT, 1'b0);
    add_req(21'h61, 1'b0); add_req(21'h1F600, 1'b0);
    // escapes cut by the last character, and one completed by it
    add_req(CP_PCT, 1'b0); add_req(21'h34, 1'b1);
    add_req(CP_PCT, 1'b1);
    add_req(CP_PCT, 1'b0); add_req(21'h34, 1'b0); add_req(21'h31, 1'b1);

    // random: mostly well-formed escapes and text, some broken escapes
    while (req_total < N_REQS) begin
      fin = ($urandom_range(9) == 0);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          add_req(CP_PCT, 1'b0);
          add_req(rand_hex_char(), 1'b0);
          add_req(rand_hex_char(), fin);
        end
        4: begin
          add_req(CP_PCT, 1'b0);
          add_req(rand_code_point(), fin);
        end
        5: begin
          add_req(CP_PCT, 1'b0);
          add_req(rand_hex_char(), 1'b0);
          c = rand_code_point();
          add_req(c, fin);
        end
        6: begin
          add_req(CP_PCT, 1'b0);
          add_req(rand_hex_char(), fin);
        end
        default: begin
          add_req(rand_code_point(), fin);
        end
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (char_reqs.size() != 0 || push || exp_bytes.size() != 0) @(posedge clk);
    rx_stall_pct = 0;
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && exp_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
